/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

/* rtl/core/swag_pkg.sv */
package swag_pkg;

  // Field and register widths
  localparam int unsigned ImgW     = 8;
  localparam int unsigned KerW     = 4;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    RegImageSize  = 2'd0,
    RegKernelSize = 2'd1,
    RegStride     = 2'd2
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [ImgW-1:0] ImageSizeRst  = 8'd8;
  localparam logic [KerW-1:0] KernelSizeRst = 4'd3;
  localparam logic [KerW-1:0] StrideRst     = 4'd1;

endpackage

/* rtl/core/sliding_window_address_gen.sv */
// Result valid rises on the output register in the cycle after an input transfer.
// Throughput: 1 item per cycle while the receiver is ready; the position counters and the index multiply
// sit between the counter registers and the result register.
// Reset: asynchronous, active low; counters clear to the origin, registers
// return to image_size 8, kernel_size 3, stride 1, and the output goes empty.
module sliding_window_address_gen #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [swag_pkg::CfgAddrW-1:0] cfg_idx_i,
  input  logic [swag_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [INDEX_WIDTH-1:0]        element_index_o,
  output logic                          window_done_o,
  output logic                          sweep_done_o,
  output logic                          size_error_o
);
  import swag_pkg::*;

  `include "assert_macros.svh"

  // Product width: row sum (9 bits) times image size (8 bits) plus column sum
  localparam int unsigned ProdW = 18;
  localparam int unsigned CalcW = (INDEX_WIDTH > ProdW) ? INDEX_WIDTH : ProdW;

  // Configuration registers
  logic [ImgW-1:0] image_size_q;
  logic [KerW-1:0] kernel_size_q;
  logic [KerW-1:0] stride_q;

  // Sweep position
  logic [ImgW-1:0] win_row_q, win_row_d;
  logic [ImgW-1:0] win_col_q, win_col_d;
  logic [KerW-1:0] ker_row_q, ker_row_d;
  logic [KerW-1:0] ker_col_q, ker_col_d;

  // Result register
  logic                   out_valid_q;
  logic [INDEX_WIDTH-1:0] index_q, index_d;
  logic                   win_done_q, win_done_d;
  logic                   swp_done_q, swp_done_d;
  logic                   size_err_q, size_err_d;

  logic in_xfer;

  // Take a new item whenever the result register is empty or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q  <= ImageSizeRst;
      kernel_size_q <= KernelSizeRst;
      stride_q      <= StrideRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegImageSize:  image_size_q  <= cfg_data_i[ImgW-1:0];
        RegKernelSize: kernel_size_q <= cfg_data_i[KerW-1:0];
        RegStride:     stride_q      <= cfg_data_i[KerW-1:0];
        default: ;
      endcase
    end
  end

  // Position and result computation
  logic [KerW-1:0]  k_eff, s_eff;
  logic             too_big, stale;
  logic [ImgW-1:0]  wr0, wc0, wr1, wc1;
  logic [KerW-1:0]  kr0, kc0, kr1, kc1;
  logic [CalcW-1:0] row_sum, col_sum, idx_full;
  logic [9:0]       col_next_end, row_next_end;

  always_comb begin
    // A zero kernel size or stride behaves as one
    k_eff = (kernel_size_q == '0) ? KerW'(1) : kernel_size_q;
    s_eff = (stride_q == '0) ? KerW'(1) : stride_q;

    // Restart clears the position before anything else
    wr0 = restart_i ? '0 : win_row_q;
    wc0 = restart_i ? '0 : win_col_q;
    kr0 = restart_i ? '0 : ker_row_q;
    kc0 = restart_i ? '0 : ker_col_q;

    too_big = {4'b0, k_eff} > image_size_q;

    // Position left invalid by a register change: start over at the origin
    stale = ({1'b0, wr0} + 9'(k_eff) > {1'b0, image_size_q}) ||
            ({1'b0, wc0} + 9'(k_eff) > {1'b0, image_size_q}) ||
            (kr0 >= k_eff) || (kc0 >= k_eff);

    wr1 = stale ? '0 : wr0;
    wc1 = stale ? '0 : wc0;
    kr1 = stale ? '0 : kr0;
    kc1 = stale ? '0 : kc0;

    row_sum  = CalcW'(wr1) + CalcW'(kr1);
    col_sum  = CalcW'(wc1) + CalcW'(kc1);
    idx_full = row_sum * CalcW'(image_size_q) + col_sum;

    col_next_end = 10'(wc1) + 10'(s_eff) + 10'(k_eff);
    row_next_end = 10'(wr1) + 10'(s_eff) + 10'(k_eff);

    win_row_d  = wr1;
    win_col_d  = wc1;
    ker_row_d  = kr1;
    ker_col_d  = kc1;
    swp_done_d = 1'b0;

    // Advance kernel column, then kernel row, then window across and down
    if ({1'b0, kc1} + 5'd1 < {1'b0, k_eff}) begin
      ker_col_d = kc1 + KerW'(1);
    end else begin
      ker_col_d = '0;
      if ({1'b0, kr1} + 5'd1 < {1'b0, k_eff}) begin
        ker_row_d = kr1 + KerW'(1);
      end else begin
        ker_row_d = '0;
        if (col_next_end <= 10'(image_size_q)) begin
          win_col_d = ImgW'(10'(wc1) + 10'(s_eff));
        end else begin
          win_col_d = '0;
          if (row_next_end <= 10'(image_size_q)) begin
            win_row_d = ImgW'(10'(wr1) + 10'(s_eff));
          end else begin
            win_row_d  = '0;
            swp_done_d = 1'b1;
          end
        end
      end
    end

    index_d    = idx_full[INDEX_WIDTH-1:0];
    win_done_d = (kr1 == k_eff - KerW'(1)) && (kc1 == k_eff - KerW'(1));
    size_err_d = 1'b0;

    // Kernel larger than image: flag it, emit zero, hold the (restarted) position
    if (too_big) begin
      win_row_d  = wr0;
      win_col_d  = wc0;
      ker_row_d  = kr0;
      ker_col_d  = kc0;
      index_d    = '0;
      win_done_d = 1'b0;
      swp_done_d = 1'b0;
      size_err_d = 1'b1;
    end
  end

  // Advance the position on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_row_q <= '0;
      win_col_q <= '0;
      ker_row_q <= '0;
      ker_col_q <= '0;
    end else if (in_xfer) begin
      win_row_q <= win_row_d;
      win_col_q <= win_col_d;
      ker_row_q <= ker_row_d;
      ker_col_q <= ker_col_d;
    end
  end

  // Result valid: set on input transfer, drop once the result transfers out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      index_q    <= index_d;
      win_done_q <= win_done_d;
      swp_done_q <= swp_done_d;
      size_err_q <= size_err_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign element_index_o = index_q;
  assign window_done_o   = win_done_q;
  assign sweep_done_o    = swp_done_q;
  assign size_error_o    = size_err_q;

  // The last element of the sweep always closes a window
  `ASSERT_IMPLIES(a_sweep_closes_window, clk_i, rst_ni, out_valid_o && sweep_done_o, window_done_o)
  // An oversized kernel yields index zero and no done flags
  `ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, out_valid_o && size_error_o, (element_index_o == '0) && !window_done_o && !sweep_done_o)
  // Every input transfer shows up as a valid result in the next cycle
  `ASSERT_NEXT(a_xfer_to_result, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)

endmodule

/* tb/sv/tb_sliding_window_address_gen.sv */
`timescale 1ns / 1ps

module tb_sliding_window_address_gen;
  import swag_pkg::*;

  localparam int unsigned IndexW      = 16;
  localparam int unsigned RandomItems = 1850;
  // Far above the longest receiver stall plus the longest sender gap
  localparam int unsigned StuckLimit  = 2000;
  // Index 3 decodes to no register; writes to it must change nothing
  localparam logic [CfgAddrW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [IndexW-1:0] element_index;
    logic              window_done;
    logic              sweep_done;
    logic              size_error;
  } fetch_t;

  // Every DUT input starts at a known value
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgAddrW-1:0] cfg_idx_i  = RegImageSize;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                restart_i  = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [IndexW-1:0]   element_index_o;
  logic                window_done_o;
  logic                sweep_done_o;
  logic                size_error_o;

  // Predictor copy of the geometry registers and the sweep position
  logic [ImgW-1:0] cfg_img;
  logic [KerW-1:0] cfg_ker;
  logic [KerW-1:0] cfg_stride;
  logic [ImgW-1:0] win_row;
  logic [ImgW-1:0] win_col;
  logic [KerW-1:0] tap_row;
  logic [KerW-1:0] tap_col;

  logic   restart_q[$];  // restart bits waiting to be driven
  fetch_t fetch_q[$];    // predicted fetches not yet seen on the output

  // Sender and receiver pacing
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  bit          steady_sender = 1'b0;
  logic        in_fired      = 1'b0;
  logic [5:0]  rdy_tick      = '0;

  int unsigned sent_total    = 0;
  int unsigned taken_total   = 0;
  int unsigned stuck_cycles  = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned windows_seen  = 0;
  int unsigned sweeps_seen   = 0;
  int unsigned oversize_seen = 0;
  int unsigned restarts_seen = 0;
  int unsigned settings_used = 0;
  int unsigned random_items  = 0;

  always #5 clk_i = ~clk_i;

  sliding_window_address_gen #(
    .INDEX_WIDTH(IndexW)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .element_index_o(element_index_o),
    .window_done_o  (window_done_o),
    .sweep_done_o   (sweep_done_o),
    .size_error_o   (size_error_o)
  );

  // Send the sweep back to the first tap of the first window
  function automatic void home_sweep();
    win_row = '0;
    win_col = '0;
    tap_row = '0;
    tap_col = '0;
  endfunction

  // Work out the fetch for one accepted transfer and advance the position
  function automatic fetch_t predict_fetch(input logic restart);
    fetch_t      f;
    int unsigned n;
    int unsigned k;
    int unsigned s;
    f = '0;
    n = cfg_img;
    // A zero kernel or stride behaves as one
    k = (cfg_ker == 0) ? 1 : cfg_ker;
    s = (cfg_stride == 0) ? 1 : cfg_stride;
    if (restart) home_sweep();
    // Oversize kernel: flag it, emit index 0 and hold the position
    if (k > n) begin
      f.size_error = 1'b1;
      return f;
    end
    // Stale position after a geometry change: start over
    if (win_row + k > n || win_col + k > n || tap_row >= k || tap_col >= k) home_sweep();
    f.element_index = IndexW'((win_row + tap_row) * n + win_col + tap_col);
    f.window_done   = (tap_row == k - 1) && (tap_col == k - 1);
    if (tap_col + 1 < k) begin
      tap_col = tap_col + 1'b1;
    end else begin
      tap_col = '0;
      if (tap_row + 1 < k) begin
        tap_row = tap_row + 1'b1;
      end else begin
        tap_row = '0;
        // Step across while the next window still fits, else wrap down
        if (win_col + s + k <= n) begin
          win_col = win_col + ImgW'(s);
        end else begin
          win_col = '0;
          if (win_row + s + k <= n) begin
            win_row = win_row + ImgW'(s);
          end else begin
            win_row = '0;
            f.sweep_done = 1'b1;
          end
        end
      end
    end
    return f;
  endfunction

  // Write one register; only called while nothing is in flight
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegImageSize:  cfg_img    = data;
      RegKernelSize: cfg_ker    = data[KerW-1:0];
      RegStride:     cfg_stride = data[KerW-1:0];
      default: ;
    endcase
  endtask

  // Load all three registers; the unused upper data bits get random junk
  task automatic set_geometry(input int unsigned img, input int unsigned ker,
                              input int unsigned str);
    logic [CfgDataW-1:0] junk;
    junk = $urandom;
    write_reg(RegImageSize, CfgDataW'(img));
    write_reg(RegKernelSize, {junk[CfgDataW-1:KerW], KerW'(ker)});
    junk = $urandom;
    write_reg(RegStride, {junk[CfgDataW-1:KerW], KerW'(str)});
    settings_used++;
  endtask

  // Queue a fixed restart pattern, bit 0 first
  task automatic send_pattern(input logic [15:0] bits, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      restart_q.push_back(bits[i]);
      sent_total++;
    end
  endtask

  // Queue random restarts; a low percentage keeps sweeps running to the end
  task automatic send_random(input int unsigned count, input int unsigned pct);
    for (int unsigned i = 0; i < count; i++) begin
      restart_q.push_back($urandom_range(0, 99) < pct);
      sent_total++;
    end
  endtask

  // Hold off until every queued item is taken and every fetch has come back
  task automatic drain();
    while (taken_total != sent_total || fetch_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Driver: inputs change on the falling edge. Hold valid and the restart bit
  // until the transfer; the sender runs in bursts with random gaps between them.
  always @(negedge clk_i) begin
    rdy_tick <= rdy_tick + 1'b1;
    // Receiver pattern in turn: always ready, coin flip, one in four,
    // then a stall followed by a stretch of ready cycles
    case (rdy_tick[5:4])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= 1'($urandom_range(0, 1));
      2'd2:    out_ready_i <= (rdy_tick[1:0] == 2'd0);
      default: out_ready_i <= (rdy_tick[3:0] >= 4'd10);
    endcase
    if (!in_valid_i || in_fired) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (restart_q.size() != 0) begin
        in_valid_i <= 1'b1;
        restart_i  <= restart_q.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: sample both channels on the rising edge. Predict on each input
  // transfer and compare each output transfer with the oldest prediction.
  always @(posedge clk_i) begin : monitor
    fetch_t got;
    fetch_t want;
    logic   moved;
    moved    = 1'b0;
    in_fired <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      fetch_q.push_back(predict_fetch(restart_i));
      taken_total++;
      restarts_seen += restart_i;
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {element_index_o, window_done_o, sweep_done_o, size_error_o};
      results_seen++;
      moved = 1'b1;
      if (fetch_q.size() == 0) begin
        $error("unexpected result: element_index %0d with nothing outstanding",
               got.element_index);
        mismatches++;
      end else begin
        want = fetch_q.pop_front();
        if (got.element_index !== want.element_index) begin
          $error("element_index: expected %0d, got %0d", want.element_index, got.element_index);
          mismatches++;
        end
        if (got.window_done !== want.window_done) begin
          $error("window_done: expected %0b, got %0b", want.window_done, got.window_done);
          mismatches++;
        end
        if (got.sweep_done !== want.sweep_done) begin
          $error("sweep_done: expected %0b, got %0b", want.sweep_done, got.sweep_done);
          mismatches++;
        end
        if (got.size_error !== want.size_error) begin
          $error("size_error: expected %0b, got %0b", want.size_error, got.size_error);
          mismatches++;
        end
        windows_seen  += want.window_done;
        sweeps_seen   += want.sweep_done;
        oversize_seen += want.size_error;
      end
    end
    if (!rst_ni || moved) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  // Watchdog: end the run if nothing transfers for too long
  initial begin : watchdog
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $error("no transfer on either channel for %0d cycles", StuckLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned img;
    int unsigned ker;
    int unsigned str;
    int unsigned sel;
    int unsigned pct;
    int unsigned count;
    cfg_img    = ImageSizeRst;
    cfg_ker    = KernelSizeRst;
    cfg_stride = StrideRst;
    home_sweep();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry (8x8, 3x3 kernel, stride 1): restart on the second item,
    // then run on past the end of the first window
    send_pattern(16'b0000_0000_0000_0010, 11);
    drain();
    // Shrink the image under the second window: the stale position restarts
    set_geometry(3, 3, 1);
    send_pattern(16'h0000, 2);
    drain();
    // Kernel larger than the image; the restart in the middle still clears
    set_geometry(8, 9, 1);
    send_pattern(16'b010, 3);
    drain();
    // Empty image with a zero kernel and stride: still oversize
    set_geometry(0, 0, 0);
    send_pattern(16'h0000, 1);
    drain();
    // Zero kernel and stride act as one: walk the 2x2 image and wrap
    set_geometry(2, 0, 0);
    send_pattern(16'h0000, 5);
    drain();
    // A write to the unused index must leave the geometry alone
    write_reg(RegUnused, 8'hA5);
    // One-element image: every fetch ends both a window and the sweep
    set_geometry(1, 1, 15);
    send_pattern(16'h0000, 1);
    drain();
    // Largest image, kernel and stride
    set_geometry(255, 15, 15);
    send_pattern(16'h0000, 3);
    drain();

    // One full sweep of the largest image with stride 15 reaches the top
    // index bits and ends with a sweep wrap
    set_geometry(255, 1, 15);
    send_random(300, 0);
    random_items += 300;
    drain();

    // Random geometries: mostly small images so sweeps complete often, some
    // large ones and some oversize kernels. Positions carry over between
    // settings, so stale positions come up on their own.
    while (random_items < RandomItems) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        img = $urandom_range(0, 14);
        ker = $urandom_range(img + 1, 15);
      end else if (sel == 1) begin
        img = $urandom_range(200, 255);
        ker = $urandom_range(0, 15);
      end else begin
        img = $urandom_range(1, 16);
        ker = $urandom_range(0, (img < 15) ? img : 15);
      end
      str   = $urandom_range(0, 15);
      pct   = ($urandom_range(0, 4) == 0) ? 40 : 2;
      count = $urandom_range(40, 160);
      steady_sender = ($urandom_range(0, 3) == 0);
      set_geometry(img, ker, str);
      send_random(count, pct);
      random_items += count;
      drain();
    end

    // Let anything stray surface before the verdict
    drain();
    repeat (3) @(negedge clk_i);
    if (fetch_q.size() != 0) begin
      $error("%0d predicted fetches never arrived", fetch_q.size());
      mismatches++;
    end
    $display("Checked %0d fetches over %0d geometry settings, %0d of them after a restart.",
             results_seen, settings_used, restarts_seen);
    $display("Saw %0d window ends, %0d sweep wraps and %0d oversize-kernel flags.",
             windows_seen, sweeps_seen, oversize_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sliding_window_address_gen.f */
+incdir+rtl/core
rtl/core/swag_pkg.sv
rtl/core/sliding_window_address_gen.sv
tb/sv/tb_sliding_window_address_gen.sv
